// ----- rtl/core/bed_pkg.sv -----
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Shared types, character codes and the hex digit helper.
// ----------------------------------------------------------------------------
package bed_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] LETTER_N  = 8'h6E;
	localparam logic [7:0] LETTER_R  = 8'h72;
	localparam logic [7:0] LETTER_T  = 8'h74;
	localparam logic [7:0] LETTER_E  = 8'h65;
	localparam logic [7:0] LETTER_X  = 8'h78;

	// Depth of the command queue between the front and the back.
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} out_item_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_BSLASH = 2'd1,
		MODE_HEX0   = 2'd2,
		MODE_HEX1   = 2'd3
	} mode_t;

	// One decoded input byte: one or two output bytes.
	typedef struct packed {
		logic       two;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] b);
		hex_t h;
		h.is_hex = 1'b0;
		h.val    = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.is_hex = 1'b1;
			h.val    = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.is_hex = 1'b1;
			h.val    = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.is_hex = 1'b1;
			h.val    = 4'(b - 8'h37);
		end
		return h;
	endfunction

endpackage

// ----- rtl/core/bed_front.sv -----
// ----------------------------------------------------------------------------
// Escape decoder front end
// Accepts source bytes, tracks the escape state and issues byte commands.
// ----------------------------------------------------------------------------
module bed_front import bed_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     push,
	output cmd_t     cmd
);

	mode_t      mode_q, mode_d;
	logic [3:0] partial_q, partial_d;
	logic       take;
	logic       emit;
	hex_t       h;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign push     = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			partial_q <= 4'd0;
		end else if (take) begin
			mode_q    <= mode_d;
			partial_q <= partial_d;
		end
	end

	always_comb begin
		h         = hex_value(in_data.in_byte);
		mode_d    = MODE_NORMAL;
		partial_d = partial_q;
		emit      = 1'b1;
		cmd.two   = 1'b0;
		cmd.byte0 = in_data.in_byte;
		cmd.byte1 = in_data.in_byte;
		cmd.last  = in_data.in_last;
		unique case (mode_q)
			MODE_BSLASH: begin
				unique case (in_data.in_byte)
					LETTER_N:  cmd.byte0 = CH_LF;
					LETTER_R:  cmd.byte0 = CH_CR;
					LETTER_T:  cmd.byte0 = CH_TAB;
					CH_BSLASH: cmd.byte0 = CH_BSLASH;
					LETTER_E:  cmd.byte0 = CH_ESC;
					LETTER_X: begin
						cmd.byte0 = CH_NUL;
						if (!in_data.in_last) begin
							emit      = 1'b0;
							mode_d    = MODE_HEX0;
							partial_d = 4'd0;
						end
					end
					default: begin
						cmd.two   = 1'b1;
						cmd.byte0 = CH_BSLASH;
					end
				endcase
			end
			MODE_HEX0, MODE_HEX1: begin
				if (h.is_hex) begin
					if (mode_q == MODE_HEX1) begin
						cmd.byte0 = {partial_q, h.val};
					end else begin
						cmd.byte0 = {4'd0, h.val};
						if (!in_data.in_last) begin
							emit      = 1'b0;
							mode_d    = MODE_HEX1;
							partial_d = h.val;
						end
					end
				end else begin
					// Pending value out, then the byte, unless it opens a new escape.
					cmd.byte0 = (mode_q == MODE_HEX1) ? {4'd0, partial_q} : CH_NUL;
					if (in_data.in_byte == CH_BSLASH && !in_data.in_last) begin
						mode_d = MODE_BSLASH;
					end else begin
						cmd.two = 1'b1;
					end
				end
			end
			default: begin
				if (in_data.in_byte == CH_BSLASH && !in_data.in_last) begin
					emit   = 1'b0;
					mode_d = MODE_BSLASH;
				end
			end
		endcase
	end

endmodule

// ----- rtl/core/bed_queue.sv -----
// ----------------------------------------------------------------------------
// Escape decoder command queue
// Small register FIFO between the front end and the output stage.
// ----------------------------------------------------------------------------
module bed_queue import bed_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t             entry_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QPtrW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QPtrW+1)'(QDepth));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/bed_back.sv -----
// ----------------------------------------------------------------------------
// Escape decoder output stage
// Turns queued commands into output bytes, one per cycle while out_ready allows, into a register.
// ----------------------------------------------------------------------------
module bed_back import bed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  logic      empty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      valid_q;
	logic      second_q;
	out_item_t data_q;
	out_item_t next;
	logic      load;
	logic      first_of_two;

	assign out_valid    = valid_q;
	assign out_data     = data_q;
	assign load         = !valid_q || out_ready;
	assign first_of_two = head.two && !second_q;
	assign pop          = load && !empty && !first_of_two;

	always_comb begin
		next.out_byte   = second_q ? head.byte1 : head.byte0;
		next.run_last   = !first_of_two;
		next.string_end = !first_of_two && head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				second_q <= first_of_two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			data_q <= next;
		end
	end

endmodule

// ----- rtl/core/backslash_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// Backslash escape decoder
// Decodes a byte stream with backslash and hex escapes into output bytes.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                     | Transaction
//   --------+-----------------------------+-----------------------------------
//   in      | in_valid, in_ready, in_data | one source byte with its end flag
//   out     | out_valid, out_ready, out_data | one decoded byte with flags
//
// The block takes one source byte per cycle while the queue is not full and
// gives one decoded byte per cycle while out_ready allows. A source byte that
// expands to two output bytes holds the output stage for an extra byte; the
// four-entry command queue absorbs this, so the input only stalls when the
// queue fills. An accepted byte's command is written into the queue and then
// loaded into the output register. Reset clears the escape state, the queue
// and the output valid flag. in_ready depends only on queue fill, not out_ready.
//
module backslash_escape_decoder import bed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t cmd;
	cmd_t head;

	// The front end classifies each source transaction and keeps the escape
	// state; bytes that only open or extend an escape produce no command.
	bed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.cmd      (cmd)
	);

	// Commands wait here so that either side can stall on its own.
	bed_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// The back end issues one output byte per cycle from the queue head while out_ready allows.
	bed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
